// ===== rtl/gnd_pkg.sv =====
package gnd_pkg;

	localparam int SW    = 10;
	localparam int LW    = 32;
	localparam int DIM_W = 6;
	localparam int CFG_IW = 1;
	localparam int MAX_DIM = 32;

	localparam logic [CFG_IW-1:0] REG_FIRST_DIM  = 1'd0;
	localparam logic [CFG_IW-1:0] REG_SECOND_DIM = 1'd1;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_AREA,
		OP_RANGE,
		OP_WRITE,
		OP_SPLIT,
		OP_CUT,
		OP_LEAF,
		OP_ADDR,
		OP_READ,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_REQ,
		C_WRITE,
		C_HIT,
		C_LEAF,
		C_SEP,
		C_LEAF_END,
		C_OUT_FREE
	} cond_t;

	typedef enum logic [3:0] {
		ST_ACCEPT,
		ST_AREA,
		ST_WRITE,
		ST_RANGE,
		ST_SPLIT,
		ST_CUT,
		ST_LEAF,
		ST_ADDR,
		ST_READ,
		ST_EMIT
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jt;
		step_t jf;
	} uword_t;

	typedef struct packed {
		logic req;
		logic write;
		logic hit;
		logic leaf;
		logic sep;
		logic leaf_end;
		logic out_free;
	} flags_t;

	function automatic uword_t microcode(step_t s);
		uword_t w;
		unique case (s)
			ST_ACCEPT: w = '{OP_LOAD,  C_REQ,      ST_AREA,   ST_ACCEPT};
			ST_AREA:   w = '{OP_AREA,  C_WRITE,    ST_WRITE,  ST_RANGE};
			ST_WRITE:  w = '{OP_WRITE, C_ALWAYS,   ST_EMIT,   ST_EMIT};
			ST_RANGE:  w = '{OP_RANGE, C_HIT,      ST_SPLIT,  ST_EMIT};
			ST_SPLIT:  w = '{OP_SPLIT, C_LEAF,     ST_LEAF,   ST_CUT};
			ST_CUT:    w = '{OP_CUT,   C_SEP,      ST_ADDR,   ST_SPLIT};
			ST_LEAF:   w = '{OP_LEAF,  C_LEAF_END, ST_ADDR,   ST_LEAF};
			ST_ADDR:   w = '{OP_ADDR,  C_ALWAYS,   ST_READ,   ST_READ};
			ST_READ:   w = '{OP_READ,  C_ALWAYS,   ST_EMIT,   ST_EMIT};
			ST_EMIT:   w = '{OP_EMIT,  C_OUT_FREE, ST_ACCEPT, ST_EMIT};
			default:   w = '{OP_NONE,  C_ALWAYS,   ST_ACCEPT, ST_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/gnd_if.sv =====
interface gnd_in_if;
	logic              valid;
	logic              ready;
	logic              action;
	logic [9:0]        slot;
	logic signed [31:0] label;

	modport source (output valid, action, slot, label, input ready);
	modport sink   (input valid, action, slot, label, output ready);
endinterface

interface gnd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cell_label;
	logic [9:0]         cell_address;
	logic               position_valid;

	modport source (output valid, cell_label, cell_address, position_valid, input ready);
	modport sink   (input valid, cell_label, cell_address, position_valid, output ready);
endinterface

// ===== rtl/gnd_ram.sv =====
module gnd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/gnd_seq.sv =====
module gnd_seq
	import gnd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output op_t    op
);

	step_t  pc_q;
	step_t  pc_d;
	uword_t word;
	logic   taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_ACCEPT;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		word = microcode(pc_q);
		unique case (word.cond)
			C_ALWAYS:   taken = 1'b1;
			C_REQ:      taken = flags.req;
			C_WRITE:    taken = flags.write;
			C_HIT:      taken = flags.hit;
			C_LEAF:     taken = flags.leaf;
			C_SEP:      taken = flags.sep;
			C_LEAF_END: taken = flags.leaf_end;
			C_OUT_FREE: taken = flags.out_free;
		endcase
		pc_d = taken ? word.jt : word.jf;
		op   = word.op;
	end

endmodule

// ===== rtl/gnd_dp.sv =====
module gnd_dp
	import gnd_pkg::*;
#(
	parameter int LEAF_LIMIT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	gnd_in_if.sink            req,
	gnd_out_if.source         rsp,
	input  op_t               op,
	output flags_t            flags
);

	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int PW    = 2 * DW;
	localparam int CW    = (SW > PW) ? SW : PW;
	localparam int Depth = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(Depth);

	logic [DIM_W-1:0]   first_q;
	logic [DIM_W-1:0]   second_q;
	logic               act_q;
	logic signed [LW-1:0] label_q;
	logic [DW-1:0]      w_q;
	logic [DW-1:0]      h_q;
	logic [DW-1:0]      wf_q;
	logic [SW-1:0]      p_q;
	logic [DW-1:0]      oi_q;
	logic [DW-1:0]      oj_q;
	logic [DW-1:0]      ci_q;
	logic [DW-1:0]      cj_q;
	logic [DW-1:0]      mid_q;
	logic [PW-1:0]      t1_q;
	logic [PW-1:0]      t2_q;
	logic [PW-1:0]      addr_q;
	logic               hit_q;
	logic               ov_q;
	logic signed [LW-1:0] olabel_q;
	logic [SW-1:0]      oaddr_q;
	logic               opos_q;

	logic [DW-1:0] len_c;
	logic [DW-1:0] oth_c;
	logic          wider_c;
	logic [DW-1:0] mid_c;
	logic [PW-1:0] t1_c;
	logic [PW-1:0] t2_c;
	logic [PW-1:0] area_c;
	logic [CW-1:0] p_x;
	logic [CW-1:0] t1_x;
	logic [CW-1:0] t2_x;
	logic [CW-1:0] off2_c;
	logic          lt1_c;
	logic          lt2_c;
	logic          out_free;
	logic          ram_we;
	logic [LW-1:0] ram_rdata;

	function automatic logic [DW-1:0] clamp_dim(logic [DIM_W-1:0] d);
		if (d == '0) begin
			return DW'(1);
		end else if (int'(d) > MAX_DIM) begin
			return DW'(MAX_DIM);
		end else begin
			return DW'(d);
		end
	endfunction

	always_comb begin
		wider_c = w_q > h_q;
		len_c   = wider_c ? w_q : h_q;
		oth_c   = wider_c ? h_q : w_q;
		mid_c   = DW'(({1'b0, len_c} + 1'b1) >> 1);
		t1_c    = PW'(mid_c - DW'(1)) * PW'(oth_c);
		t2_c    = PW'(len_c - DW'(1)) * PW'(oth_c);
		area_c  = PW'(w_q) * PW'(h_q);
		p_x     = CW'(p_q);
		t1_x    = CW'(t1_q);
		t2_x    = CW'(t2_q);
		off2_c  = p_x - t2_x;
		lt1_c   = p_x < t1_x;
		lt2_c   = p_x < t2_x;
		out_free = !ov_q || rsp.ready;
	end

	assign flags.req      = req.valid;
	assign flags.write    = act_q == ACT_WRITE;
	assign flags.hit      = lt2_c;
	assign flags.leaf     = (int'(w_q) <= LEAF_LIMIT) && (int'(h_q) <= LEAF_LIMIT);
	assign flags.sep      = !lt2_c;
	assign flags.leaf_end = p_x < CW'(w_q);
	assign flags.out_free = out_free;

	assign req.ready = op == OP_LOAD;

	assign rsp.valid          = ov_q;
	assign rsp.cell_label     = olabel_q;
	assign rsp.cell_address   = oaddr_q;
	assign rsp.position_valid = opos_q;

	assign ram_we = (op == OP_WRITE) && (32'(p_q) < 32'(Depth));

	gnd_ram #(
		.WIDTH(LW),
		.DEPTH(Depth)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(p_q)),
		.wdata(label_q),
		.re   (op == OP_READ),
		.raddr(AW'(addr_q)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= DIM_W'(1);
			second_q <= DIM_W'(1);
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_FIRST_DIM) begin
				first_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_SECOND_DIM) begin
				second_q <= cfg_data;
			end
			if (op == OP_EMIT && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (req.valid) begin
					act_q   <= req.action;
					p_q     <= req.slot;
					label_q <= req.label;
					w_q     <= clamp_dim(first_q);
					h_q     <= clamp_dim(second_q);
					wf_q    <= clamp_dim(first_q);
					oi_q    <= '0;
					oj_q    <= '0;
				end
			end
			OP_AREA: begin
				t2_q <= area_c;
			end
			OP_WRITE: begin
				hit_q <= 1'b0;
			end
			OP_RANGE: begin
				hit_q <= lt2_c;
			end
			OP_SPLIT: begin
				mid_q <= mid_c;
				t1_q  <= t1_c;
				t2_q  <= t2_c;
			end
			OP_CUT: begin
				if (lt1_c) begin
					if (wider_c) begin
						w_q <= mid_q - DW'(1);
					end else begin
						h_q <= mid_q - DW'(1);
					end
				end else if (lt2_c) begin
					p_q <= SW'(p_x - t1_x);
					if (wider_c) begin
						oi_q <= oi_q + mid_q;
						w_q  <= w_q - mid_q;
					end else begin
						oj_q <= oj_q + mid_q;
						h_q  <= h_q - mid_q;
					end
				end else begin
					if (wider_c) begin
						ci_q <= oi_q + mid_q - DW'(1);
						cj_q <= oj_q + DW'(off2_c);
					end else begin
						ci_q <= oi_q + DW'(off2_c);
						cj_q <= oj_q + mid_q - DW'(1);
					end
				end
			end
			OP_LEAF: begin
				if (p_x >= CW'(w_q)) begin
					p_q  <= p_q - SW'(w_q);
					oj_q <= oj_q + DW'(1);
				end else begin
					ci_q <= oi_q + DW'(p_q);
					cj_q <= oj_q;
				end
			end
			OP_ADDR: begin
				addr_q <= PW'(ci_q) + PW'(wf_q) * PW'(cj_q);
			end
			OP_EMIT: begin
				if (out_free) begin
					olabel_q <= hit_q ? ram_rdata : '0;
					oaddr_q  <= hit_q ? SW'(addr_q) : '0;
					opos_q   <= hit_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/grid_nested_dissection_order.sv =====
// Nested dissection ordering of a first_dim by second_dim grid with a label store.
// Channels: req (action, slot, label) in, rsp (cell_label, cell_address,
// position_valid) out, both valid/ready; a request is taken when both are high.
// Config: cfg_we with cfg_index 0 (first_dim) or 1 (second_dim) and cfg_data;
// write it only while no request is in flight.
// A write request stores label at slot and answers with an all-zero result;
// an out-of-range query also answers with an all-zero result.
// A query answers after L cut levels of the descent, each one split step and
// one compare step, K leaf steps (at most LEAF_LIMIT), then address multiply,
// store read and output load. The descent sequencer handles one request at a time
// and takes the next one the cycle after a result is loaded into the output
// register, so work on it overlaps a result that still waits for rsp.ready.
// A stalled receiver holds the result; the block then finishes the next
// request and waits in its output step.
// Reset sets both extents to 1 and empties the output register. The store
// is not cleared: read only cells that were written.
module grid_nested_dissection_order
	import gnd_pkg::*;
#(
	parameter int LEAF_LIMIT = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	gnd_in_if.sink            req,
	gnd_out_if.source         rsp
);

	op_t    op;
	flags_t flags;

	gnd_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.op    (op)
	);

	gnd_dp #(
		.LEAF_LIMIT(LEAF_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp),
		.op       (op),
		.flags    (flags)
	);

endmodule

// ===== rtl/gnd_check.sv =====
module gnd_check (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_cell_label,
	input logic [9:0]  rsp_cell_address,
	input logic        rsp_position_valid
);

	logic [1:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_position_valid |-> rsp_cell_label == '0 && rsp_cell_address == '0)
		else $error("invalid position with nonzero payload");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in descent");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without a pending request");

endmodule

bind grid_nested_dissection_order gnd_check u_check (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_cell_label    (rsp.cell_label),
	.rsp_cell_address  (rsp.cell_address),
	.rsp_position_valid(rsp.position_valid)
);

// ===== bench/dissection_checker.sv =====
module dissection_checker
	import gnd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	gnd_in_if                 req,
	gnd_out_if                rsp,
	output int                fails,
	output int                pending
);

	localparam int GRID_MAX  = 32;
	localparam int LEAF_SPAN = 3;

	typedef struct packed {
		logic signed [LW-1:0] cell_label;
		logic [SW-1:0]        cell_address;
		logic                 position_valid;
	} answer_t;

	logic [DIM_W-1:0]     first_extent;
	logic [DIM_W-1:0]     second_extent;
	logic signed [LW-1:0] label_mem [GRID_MAX*GRID_MAX];
	answer_t              answers [$];

	function automatic int unsigned fit_extent(logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > GRID_MAX)
			return GRID_MAX;
		return d;
	endfunction

	function automatic int unsigned dissect_cell(int unsigned gw, int unsigned gh,
			int unsigned pos);
		int unsigned w, h, p, col, row, mid, lo, hi;
		bit done;
		w = gw;
		h = gh;
		p = pos;
		col = 0;
		row = 0;
		done = 1'b0;
		while (!done) begin
			if (w <= LEAF_SPAN && h <= LEAF_SPAN) begin
				col += p % w;
				row += p / w;
				done = 1'b1;
			end else if (w > h) begin
				mid = (w + 1) / 2;
				lo = mid - 1;
				hi = w - mid;
				if (p < lo * h) begin
					w = lo;
				end else if (p < (lo + hi) * h) begin
					p -= lo * h;
					col += mid;
					w = hi;
				end else begin
					p -= (lo + hi) * h;
					col += mid - 1;
					row += p;
					done = 1'b1;
				end
			end else begin
				mid = (h + 1) / 2;
				lo = mid - 1;
				hi = h - mid;
				if (p < w * lo) begin
					h = lo;
				end else if (p < w * (lo + hi)) begin
					p -= w * lo;
					row += mid;
					h = hi;
				end else begin
					p -= w * (lo + hi);
					col += p;
					row += mid - 1;
					done = 1'b1;
				end
			end
		end
		return col + gw * row;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t got, want;
		int unsigned w, h, addr;
		if (!arst_n) begin
			first_extent = 1;
			second_extent = 1;
			answers.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.cell_label, rsp.cell_address, rsp.position_valid};
				if (answers.size() == 0) begin
					$display("%0t: result with no request waiting: label %0d address %0d valid %0b",
						$time, got.cell_label, got.cell_address, got.position_valid);
					fails++;
				end else begin
					want = answers.pop_front();
					if (got.cell_label !== want.cell_label) begin
						$display("%0t: cell_label mismatch: expected %0d, actual %0d",
							$time, want.cell_label, got.cell_label);
						fails++;
					end
					if (got.cell_address !== want.cell_address) begin
						$display("%0t: cell_address mismatch: expected %0d, actual %0d",
							$time, want.cell_address, got.cell_address);
						fails++;
					end
					if (got.position_valid !== want.position_valid) begin
						$display("%0t: position_valid mismatch: expected %0b, actual %0b",
							$time, want.position_valid, got.position_valid);
						fails++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want = '0;
				if (req.action == ACT_WRITE) begin
					label_mem[req.slot] = req.label;
				end else begin
					w = fit_extent(first_extent);
					h = fit_extent(second_extent);
					if (req.slot < w * h) begin
						addr = dissect_cell(w, h, req.slot);
						want.cell_label = label_mem[addr];
						want.cell_address = addr[SW-1:0];
						want.position_valid = 1'b1;
					end
				end
				answers.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_DIM: first_extent = cfg_data;
					REG_SECOND_DIM: second_extent = cfg_data;
					default: ;
				endcase
			end
			pending = answers.size();
		end
	end

endmodule

// ===== bench/grid_nested_dissection_order_tb.sv =====
module grid_nested_dissection_order_tb;
	import gnd_pkg::*;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES     = 600000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [DIM_W-1:0]  cfg_data;
	int                fails;
	int                pending;

	bit written [1024];
	bit quiet;
	bit long_hold;
	int requests_sent;
	int queries_sent;
	int settings_used;

	gnd_in_if  req_ch ();
	gnd_out_if rsp_ch ();

	grid_nested_dissection_order u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	dissection_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("%0t: timeout with %0d results outstanding", $time, pending);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic act, input logic [SW-1:0] s,
			input logic [LW-1:0] lb);
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.slot <= s;
		req_ch.label <= lb;
		do @(posedge clk); while (!req_ch.ready);
		if (act == ACT_WRITE)
			written[s] = 1'b1;
		else
			queries_sent++;
		requests_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] fd, input logic [DIM_W-1:0] sd,
			output int area);
		int w, h;
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_FIRST_DIM;
		cfg_data <= fd;
		@(posedge clk);
		cfg_index <= REG_SECOND_DIM;
		cfg_data <= sd;
		@(posedge clk);
		cfg_we <= 1'b0;
		w = (fd == 0) ? 1 : ((fd > 32) ? 32 : fd);
		h = (sd == 0) ? 1 : ((sd > 32) ? 32 : sd);
		area = w * h;
		settings_used++;
		// label every cell of the grid before any query can land on it
		for (int a = 0; a < area; a++)
			if (!written[a])
				send_request(ACT_WRITE, SW'(a), $urandom);
	endtask

	task automatic random_request(input int area);
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			send_request(ACT_WRITE,
				SW'($urandom_range(0, 1) ? $urandom_range(0, area - 1)
					: $urandom_range(0, 1023)),
				$urandom);
		else if (r < 9)
			send_request(ACT_QUERY, SW'($urandom_range(0, area - 1)), $urandom);
		else
			send_request(ACT_QUERY, SW'($urandom_range(0, 1023)), $urandom);
	endtask

	task automatic run_phase(input logic [DIM_W-1:0] fd, input logic [DIM_W-1:0] sd,
			input int n);
		int area;
		set_grid(fd, sd, area);
		repeat (n) random_request(area);
	endtask

	initial begin
		int area;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FIRST_DIM;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_WRITE;
		req_ch.slot <= '0;
		req_ch.label <= '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		requests_sent = 0;
		queries_sent = 0;
		settings_used = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid is 1 by 1
		send_request(ACT_WRITE, 0, 32'h8000_0000);
		send_request(ACT_QUERY, 0, 32'h0);
		send_request(ACT_QUERY, 1, 32'hFFFF_FFFF);
		send_request(ACT_QUERY, 1023, 32'h0);
		send_request(ACT_WRITE, 1023, 32'h7FFF_FFFF);
		send_request(ACT_WRITE, 0, 32'hFFFF_FFFF);
		send_request(ACT_QUERY, 0, 32'h0);
		send_request(ACT_WRITE, 0, 32'h0);
		send_request(ACT_QUERY, 0, 32'h0);

		// zero extent saturates to 1
		set_grid(0, 5, area);
		for (int p = 0; p <= 5; p++)
			send_request(ACT_QUERY, SW'(p), 32'h0);

		// extent above the maximum saturates to 32
		set_grid(63, 1, area);
		send_request(ACT_QUERY, 0, 32'h0);
		send_request(ACT_QUERY, 15, 32'h0);
		send_request(ACT_QUERY, 31, 32'h0);
		send_request(ACT_QUERY, 32, 32'h0);

		run_phase(2, 2, 40);
		run_phase(3, 3, 40);
		run_phase(4, 3, 40);
		run_phase(3, 4, 40);
		run_phase(7, 5, 50);
		run_phase(1, 32, 40);
		run_phase(32, 1, 40);

		// hold off the receiver so the block backs up into its input
		set_grid(16, 9, area);
		long_hold = 1'b1;
		repeat (80) random_request(area);

		run_phase(13, 27, 80);
		repeat (4) run_phase(DIM_W'($urandom_range(1, 20)), DIM_W'($urandom_range(1, 20)), 40);

		quiet = 1'b1;
		run_phase(63, 9, 100);

		drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests (%0d queries) over %0d grid settings,",
			requests_sent, queries_sent, settings_used);
		$display("including saturated extents, out-of-range positions and a long output stall.");
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== grid_nested_dissection_order.f =====
rtl/gnd_pkg.sv
rtl/gnd_if.sv
rtl/gnd_ram.sv
rtl/gnd_seq.sv
rtl/gnd_dp.sv
rtl/grid_nested_dissection_order.sv
rtl/gnd_check.sv
bench/dissection_checker.sv
bench/grid_nested_dissection_order_tb.sv
